[rtl/tsb_pkg.sv]
// Shared constants, types and helpers for the tile and sprite blitter.
// Used by the top level, the lanes and the merge; it depends on nothing else.
package tsb_pkg;

    localparam int MAX_WIDTH  = 256;
    localparam int MAX_HEIGHT = 256;
    localparam int TILE_SIZE  = 8;
    localparam int PIXEL_BITS = 2;

    localparam int LANES      = TILE_SIZE;
    localparam int LW         = $clog2(LANES);
    localparam int CW         = 11;
    localparam int YW         = $clog2(MAX_HEIGHT);
    localparam int BANK_COLS  = MAX_WIDTH / LANES;
    localparam int BANK_DEPTH = BANK_COLS * MAX_HEIGHT;
    localparam int AW         = $clog2(BANK_DEPTH);
    localparam int ROW_BITS   = PIXEL_BITS * TILE_SIZE;
    localparam int TILE_BITS  = ROW_BITS * TILE_SIZE;
    localparam int TIDX_W     = $clog2(TILE_BITS);
    localparam int CFG_W      = 9;
    localparam int PIX_W      = 2 * PIXEL_BITS + 1;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(256);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(240);

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    localparam logic KIND_BLIT = 1'b0;
    localparam logic KIND_READ = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_BLIT,
        ST_READ,
        ST_RDATA
    } t_state;

    typedef struct packed {
        logic                  clear;
        logic [AW-1:0]         clr_addr;
        logic                  blit;
        logic                  row_ok;
        logic [YW-1:0]         y_lo;
        logic [CW-1:0]         px;
        logic [ROW_BITS-1:0]   row_tx;
        logic                  fh;
        logic                  sprite;
        logic [PIXEL_BITS-1:0] attr;
        logic [CW-1:0]         w_eff;
        logic                  rd_en;
        logic [AW-1:0]         rd_addr;
    } t_lane_cmd;

    function automatic logic [CW-1:0] eff_size(input logic [CFG_W-1:0] v,
                                               input logic [CW-1:0] mx);
        logic [CW-1:0] r;
        if (v == '0) begin
            r = CW'(1);
        end else if (CW'(v) > mx) begin
            r = mx;
        end else begin
            r = CW'(v);
        end
        return r;
    endfunction

endpackage

[rtl/tile_sprite_blitter_top.sv]
// Top level of the tile and sprite blitter: sequencer, lanes, merge and APB registers.
// Depends on tsb_pkg, tsb_lane and tsb_merge.
//
// After reset the block clears all 8192 entries of each frame store bank, one entry of every
// bank per cycle, and stalls input items meanwhile. A blit item is then accepted and written
// tile row by tile row, since eight lanes write the eight columns of a row at once through
// one write port per bank. A read item passes the accepting state, a bank read and the
// result register, which a stalled consumer can hold.
module tile_sprite_blitter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_kind,
    input  logic [9:0]                     i_pos_x,
    input  logic [9:0]                     i_pos_y,
    input  logic [1:0]                     i_palette_attr,
    input  logic                           i_is_sprite,
    input  logic                           i_flip_h,
    input  logic                           i_flip_v,
    input  logic [63:0]                    i_tile_rows_upper,
    input  logic [63:0]                    i_tile_rows_lower,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic [1:0]                     o_pixel_color,
    output logic [1:0]                     o_pixel_attr,
    output logic                           o_pixel_sprite,
    output logic                           o_read_in_frame,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [2:0]                     paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    tsb_pkg::t_state                   r_state, n_state;
    logic [tsb_pkg::AW-1:0]            r_clr_addr;
    logic [tsb_pkg::LW-1:0]            r_row;
    logic [tsb_pkg::CFG_W-1:0]         r_frame_width;
    logic [tsb_pkg::CFG_W-1:0]         r_frame_height;
    logic [9:0]                        r_px;
    logic [9:0]                        r_py;
    logic [1:0]                        r_attr;
    logic                              r_sprite;
    logic                              r_fh;
    logic                              r_fv;
    logic [tsb_pkg::TILE_BITS-1:0]     r_tile;
    logic                              r_out_valid;
    logic [1:0]                        r_color;
    logic [1:0]                        r_pattr;
    logic                              r_psprite;
    logic                              r_in_frame;

    logic                              accept;
    logic                              out_free;
    logic                              cfg_wr;
    logic                              do_clear;
    logic                              do_blit;
    logic                              do_read;
    logic                              do_out;
    logic [tsb_pkg::CW-1:0]            w_eff;
    logic [tsb_pkg::CW-1:0]            h_eff;
    logic signed [tsb_pkg::CW-1:0]     px_s;
    logic signed [tsb_pkg::CW-1:0]     y;
    logic [tsb_pkg::CW-1:0]            y_u;
    logic [tsb_pkg::CW-1:0]            px_u;
    logic [tsb_pkg::CW-1:0]            py_u;
    logic [tsb_pkg::LW-1:0]            tr;
    logic                              in_frame;
    tsb_pkg::t_lane_cmd                cmd;
    logic [tsb_pkg::PIX_W-1:0]         lane_data [tsb_pkg::LANES];
    logic [1:0]                        m_color;
    logic [1:0]                        m_attr;
    logic                              m_sprite;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign accept   = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign w_eff    = tsb_pkg::eff_size(r_frame_width, tsb_pkg::CW'(tsb_pkg::MAX_WIDTH));
    assign h_eff    = tsb_pkg::eff_size(r_frame_height, tsb_pkg::CW'(tsb_pkg::MAX_HEIGHT));
    assign prdata   = (paddr[2] == tsb_pkg::REG_FRAME_HEIGHT)
                      ? 32'(r_frame_height) : 32'(r_frame_width);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            tsb_pkg::ST_CLEAR: begin
                if (r_clr_addr == tsb_pkg::AW'(tsb_pkg::BANK_DEPTH - 1)) begin
                    n_state = tsb_pkg::ST_IDLE;
                end
            end
            tsb_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = (i_kind == tsb_pkg::KIND_READ) ? tsb_pkg::ST_READ
                                                             : tsb_pkg::ST_BLIT;
                end
            end
            tsb_pkg::ST_BLIT: begin
                if (r_row == tsb_pkg::LW'(tsb_pkg::TILE_SIZE - 1)) begin
                    n_state = tsb_pkg::ST_IDLE;
                end
            end
            tsb_pkg::ST_READ: begin
                n_state = tsb_pkg::ST_RDATA;
            end
            tsb_pkg::ST_RDATA: begin
                if (out_free) begin
                    n_state = tsb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = tsb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_stall = 1'b1;
        do_clear   = 1'b0;
        do_blit    = 1'b0;
        do_read    = 1'b0;
        do_out     = 1'b0;
        unique case (r_state)
            tsb_pkg::ST_CLEAR: do_clear   = 1'b1;
            tsb_pkg::ST_IDLE:  o_in_stall = 1'b0;
            tsb_pkg::ST_BLIT:  do_blit    = 1'b1;
            tsb_pkg::ST_READ:  do_read    = 1'b1;
            tsb_pkg::ST_RDATA: do_out     = out_free;
            default:           o_in_stall = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= tsb_pkg::ST_CLEAR;
            r_clr_addr     <= '0;
            r_row          <= '0;
            r_frame_width  <= tsb_pkg::WIDTH_RESET;
            r_frame_height <= tsb_pkg::HEIGHT_RESET;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (do_clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (do_blit) begin
                r_row <= r_row + 1'b1;
            end else begin
                r_row <= '0;
            end
            if (cfg_wr) begin
                if (paddr[2] == tsb_pkg::REG_FRAME_WIDTH) begin
                    r_frame_width <= pwdata[tsb_pkg::CFG_W-1:0];
                end else begin
                    r_frame_height <= pwdata[tsb_pkg::CFG_W-1:0];
                end
            end
            if (do_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_px     <= i_pos_x;
            r_py     <= i_pos_y;
            r_attr   <= i_palette_attr;
            r_sprite <= i_is_sprite;
            r_fh     <= i_is_sprite && i_flip_h;
            r_fv     <= i_is_sprite && i_flip_v;
            r_tile   <= {i_tile_rows_lower, i_tile_rows_upper};
        end
        if (do_out) begin
            r_color    <= m_color;
            r_pattr    <= m_attr;
            r_psprite  <= m_sprite;
            r_in_frame <= in_frame;
        end
    end

    always_comb begin
        px_s     = tsb_pkg::CW'($signed(r_px));
        px_u     = px_s;
        py_u     = tsb_pkg::CW'($signed(r_py));
        y        = $signed(py_u) + $signed({{(tsb_pkg::CW-tsb_pkg::LW){1'b0}}, r_row});
        y_u      = y;
        tr       = r_fv ? ~r_row : r_row;
        in_frame = !r_px[9] && !r_py[9] && (px_u < w_eff) && (py_u < h_eff);

        cmd.clear    = do_clear;
        cmd.clr_addr = r_clr_addr;
        cmd.blit     = do_blit;
        cmd.row_ok   = !y[tsb_pkg::CW-1] && (y_u < h_eff);
        cmd.y_lo     = y_u[tsb_pkg::YW-1:0];
        cmd.px       = px_u;
        cmd.row_tx   = r_tile[tsb_pkg::TIDX_W'(tr) * tsb_pkg::TIDX_W'(tsb_pkg::ROW_BITS)
                              +: tsb_pkg::ROW_BITS];
        cmd.fh       = r_fh;
        cmd.sprite   = r_sprite;
        cmd.attr     = r_attr;
        cmd.w_eff    = w_eff;
        cmd.rd_en    = do_read;
        cmd.rd_addr  = tsb_pkg::AW'(tsb_pkg::AW'(py_u[tsb_pkg::YW-1:0])
                       * tsb_pkg::AW'(tsb_pkg::BANK_COLS) + tsb_pkg::AW'(px_u >> tsb_pkg::LW));
    end

    for (genvar g = 0; g < tsb_pkg::LANES; g++) begin : g_lane
        tsb_lane u_lane (
            .i_clk      (i_clk),
            .i_lane_idx (tsb_pkg::LW'(g)),
            .i_cmd      (cmd),
            .o_rdata    (lane_data[g])
        );
    end

    tsb_merge u_merge (
        .i_lane_data (lane_data),
        .i_sel       (r_px[tsb_pkg::LW-1:0]),
        .i_in_frame  (in_frame),
        .o_color     (m_color),
        .o_attr      (m_attr),
        .o_sprite    (m_sprite)
    );

    assign o_out_valid     = r_out_valid;
    assign o_pixel_color   = r_color;
    assign o_pixel_attr    = r_pattr;
    assign o_pixel_sprite  = r_psprite;
    assign o_read_in_frame = r_in_frame;

endmodule

[rtl/tsb_lane.sv]
// One column lane with its frame store bank (colour, attribute and sprite mark).
// Depends on tsb_pkg.
module tsb_lane (
    input  logic                          i_clk,
    input  logic [tsb_pkg::LW-1:0]        i_lane_idx,
    input  tsb_pkg::t_lane_cmd            i_cmd,
    output logic [tsb_pkg::PIX_W-1:0]     o_rdata
);

    logic [2*tsb_pkg::PIXEL_BITS-1:0] r_cmem [tsb_pkg::BANK_DEPTH];
    logic                             r_smem [tsb_pkg::BANK_DEPTH];
    logic [2*tsb_pkg::PIXEL_BITS-1:0] r_crd;
    logic                             r_srd;

    logic [tsb_pkg::LW-1:0]           c;
    logic [tsb_pkg::LW-1:0]           tc;
    logic signed [tsb_pkg::CW-1:0]    x;
    logic [tsb_pkg::CW-1:0]           x_u;
    logic                             x_ok;
    logic [tsb_pkg::PIXEL_BITS-1:0]   col;
    logic                             wr_blit;
    logic                             c_we;
    logic                             s_we;
    logic [2*tsb_pkg::PIXEL_BITS-1:0] c_data;
    logic                             s_data;
    logic [tsb_pkg::AW-1:0]           wr_addr;

    always_comb begin
        c       = i_lane_idx - i_cmd.px[tsb_pkg::LW-1:0];
        x       = $signed(i_cmd.px) + $signed({{(tsb_pkg::CW-tsb_pkg::LW){1'b0}}, c});
        x_u     = x;
        x_ok    = !x[tsb_pkg::CW-1] && (x_u < i_cmd.w_eff);
        tc      = i_cmd.fh ? ~c : c;
        col     = i_cmd.row_tx[{tc, 1'b0} +: tsb_pkg::PIXEL_BITS];
        wr_blit = i_cmd.blit && i_cmd.row_ok && x_ok;
        c_we    = i_cmd.clear || (wr_blit && (!i_cmd.sprite || col != '0));
        s_we    = i_cmd.clear || wr_blit;
        c_data  = i_cmd.clear ? '0 : {i_cmd.attr, col};
        s_data  = !i_cmd.clear && i_cmd.sprite;
        if (i_cmd.clear) begin
            wr_addr = i_cmd.clr_addr;
        end else begin
            wr_addr = tsb_pkg::AW'(tsb_pkg::AW'(i_cmd.y_lo) * tsb_pkg::AW'(tsb_pkg::BANK_COLS)
                      + tsb_pkg::AW'(x_u >> tsb_pkg::LW));
        end
    end

    always_ff @(posedge i_clk) begin
        if (c_we) begin
            r_cmem[wr_addr] <= c_data;
        end
        if (s_we) begin
            r_smem[wr_addr] <= s_data;
        end
        if (i_cmd.rd_en) begin
            r_crd <= r_cmem[i_cmd.rd_addr];
            r_srd <= r_smem[i_cmd.rd_addr];
        end
    end

    assign o_rdata = {r_srd, r_crd};

endmodule

[rtl/tsb_merge.sv]
// Merges the lane read data into one pixel, zeroed outside the frame.
// Depends on tsb_pkg.
module tsb_merge (
    input  logic [tsb_pkg::PIX_W-1:0]      i_lane_data [tsb_pkg::LANES],
    input  logic [tsb_pkg::LW-1:0]         i_sel,
    input  logic                           i_in_frame,
    output logic [tsb_pkg::PIXEL_BITS-1:0] o_color,
    output logic [tsb_pkg::PIXEL_BITS-1:0] o_attr,
    output logic                           o_sprite
);

    logic [tsb_pkg::PIX_W-1:0] pix;

    always_comb begin
        pix      = i_in_frame ? i_lane_data[i_sel] : '0;
        o_color  = pix[tsb_pkg::PIXEL_BITS-1:0];
        o_attr   = pix[2*tsb_pkg::PIXEL_BITS-1:tsb_pkg::PIXEL_BITS];
        o_sprite = pix[tsb_pkg::PIX_W-1];
    end

endmodule

[rtl/tsb_checker.sv]
// Port-level checks on the blitter top level, attached by the bind below.
// Depends only on the ports of tile_sprite_blitter_top.
module tsb_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_pixel_color,
    input logic [1:0] o_pixel_attr,
    input logic       o_pixel_sprite,
    input logic       o_read_in_frame,
    input logic       pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_pixel_color)
            && $stable(o_pixel_attr) && $stable(o_pixel_sprite))
        else $error("Stalled result item changed.");

    a_outside_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_read_in_frame |-> o_pixel_color == 2'b00
            && o_pixel_attr == 2'b00 && !o_pixel_sprite)
        else $error("Read outside the frame returned stored data.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Item accepted in two consecutive cycles.");

    a_stall_in_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("Input not stalled after reset.");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("Register port not ready.");

endmodule

bind tile_sprite_blitter_top tsb_checker u_tsb_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_in_valid      (i_in_valid),
    .o_in_stall      (o_in_stall),
    .o_out_valid     (o_out_valid),
    .i_out_stall     (i_out_stall),
    .o_pixel_color   (o_pixel_color),
    .o_pixel_attr    (o_pixel_attr),
    .o_pixel_sprite  (o_pixel_sprite),
    .o_read_in_frame (o_read_in_frame),
    .pready          (pready)
);
